// ===== design/rtm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtm_pkg
// Types and fixed constants for the Reinhard tone mapping pipeline.
// ----------------------------------------------------------------------------
package rtm_pkg;

   // Rec.709 luma weights, Q0.16, summing to exactly 1.0
   localparam int unsigned WEIGHT_SHIFT = 16;
   localparam logic [15:0] W_RED   = 16'd13933;
   localparam logic [15:0] W_GREEN = 16'd46871;
   localparam logic [15:0] W_BLUE  = 16'd4732;

   localparam int unsigned OUT_BITS = 8;

   typedef struct packed {
      logic [31:0] red_in;
      logic [31:0] green_in;
      logic [31:0] blue_in;
   } pix_in_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       clipped;
   } pix_out_type;

endpackage
`default_nettype wire

// ===== design/reinhard_tone_map_pixel.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// reinhard_tone_map_pixel
// Global Reinhard tone mapping of one Q16.16 RGB pixel per request.
//
// Request channel (req_*): one HDR pixel per accepted request, taken when
// req_valid is high and req_stall is low. Result channel (rsp_*): one 8-bit
// RGB pixel plus a clipped flag per request, in request order.
// Throughput is one pixel per clock while no held result stalls the
// pipeline. Stages: weight multiply, luminance sum and 255*C, overflow
// check, then one quotient bit per stage for eight stages of a restoring
// divider that runs all three channels side by side.
// Each channel is floor(255*C/(1+L)), saturated at 255 with clipped set.
// Zero luminance gives a divisor of exactly 1.0 and so black.
// Reset (synchronous) empties the pipeline; no result is pending after it.
// When rsp_stall holds a valid result, the whole pipeline freezes and
// req_stall rises; nothing is lost or repeated. Bubbles advance freely.
// ----------------------------------------------------------------------------
module reinhard_tone_map_pixel
   import rtm_pkg::*;
#(
   parameter int unsigned FRAC_BITS     = 16,
   parameter int unsigned CHANNEL_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire pix_in_type  req_data,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      pix_out_type rsp_data
);

   localparam int unsigned CW    = (CHANNEL_WIDTH < 32) ? CHANNEL_WIDTH : 32;
   localparam int unsigned PW    = CW + WEIGHT_SHIFT;
   localparam int unsigned SW    = PW + 2;
   localparam int unsigned DW    = ((CW > FRAC_BITS) ? CW : FRAC_BITS) + 1;
   localparam int unsigned NW    = CW + OUT_BITS;
   localparam int unsigned RW    = DW + OUT_BITS;
   localparam int unsigned STEPS = OUT_BITS;

   logic en;
   assign en = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // stage 1: weighted products
   logic          v1_ff;
   logic [PW-1:0] pr_ff, pg_ff, pb_ff;
   logic [CW-1:0] c1_ff [0:2];

   // stage 2: divisor and scaled numerators
   logic          v2_ff;
   logic [DW-1:0] d2_ff;
   logic [NW-1:0] n2_ff [0:2];
   logic [SW-1:0] wsum_in;
   logic [DW-1:0] d2_in;

   // divider stages, index 0 holds the overflow check
   logic          vd_ff  [0:STEPS];
   logic [DW-1:0] dd_ff  [0:STEPS];
   logic [RW-1:0] rem_ff [0:STEPS][0:2];
   logic [7:0]    q_ff   [0:STEPS][0:2];
   logic          ov_ff  [0:STEPS][0:2];
   logic [RW-1:0] rem_in [1:STEPS][0:2];
   logic [7:0]    q_in   [1:STEPS][0:2];
   logic [RW-1:0] ov_lim;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         for (int s = 0; s <= STEPS; s++) begin
            vd_ff[s] <= 1'b0;
         end
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         vd_ff[0] <= v2_ff;
         for (int s = 1; s <= STEPS; s++) begin
            vd_ff[s] <= vd_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff[0] <= req_data.red_in[CW-1:0];
         c1_ff[1] <= req_data.green_in[CW-1:0];
         c1_ff[2] <= req_data.blue_in[CW-1:0];
         pr_ff <= PW'(W_RED)   * PW'(req_data.red_in[CW-1:0]);
         pg_ff <= PW'(W_GREEN) * PW'(req_data.green_in[CW-1:0]);
         pb_ff <= PW'(W_BLUE)  * PW'(req_data.blue_in[CW-1:0]);
      end
   end

   always_comb begin
      wsum_in = SW'(pr_ff) + SW'(pg_ff) + SW'(pb_ff);
      d2_in   = (DW'(1) << FRAC_BITS) + DW'(wsum_in[SW-1:WEIGHT_SHIFT]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d2_ff <= d2_in;
         for (int c = 0; c < 3; c++) begin
            n2_ff[c] <= (NW'(c1_ff[c]) << OUT_BITS) - NW'(c1_ff[c]);
         end
      end
   end

   assign ov_lim = RW'(d2_ff) << OUT_BITS;

   always_ff @(posedge clock) begin
      if (en) begin
         dd_ff[0] <= d2_ff;
         for (int c = 0; c < 3; c++) begin
            rem_ff[0][c] <= RW'(n2_ff[c]);
            q_ff[0][c]   <= '0;
            ov_ff[0][c]  <= (RW'(n2_ff[c]) >= ov_lim);
         end
      end
   end

   // one quotient bit per stage
   always_comb begin
      for (int s = 1; s <= STEPS; s++) begin
         for (int c = 0; c < 3; c++) begin
            rem_in[s][c] = rem_ff[s-1][c];
            q_in[s][c]   = q_ff[s-1][c];
            if (rem_ff[s-1][c] >= (RW'(dd_ff[s-1]) << (STEPS - s))) begin
               rem_in[s][c] = rem_ff[s-1][c] - (RW'(dd_ff[s-1]) << (STEPS - s));
               q_in[s][c][STEPS-s] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 1; s <= STEPS; s++) begin
            dd_ff[s] <= dd_ff[s-1];
            for (int c = 0; c < 3; c++) begin
               rem_ff[s][c] <= rem_in[s][c];
               q_ff[s][c]   <= q_in[s][c];
               ov_ff[s][c]  <= ov_ff[s-1][c];
            end
         end
      end
   end

   assign rsp_valid = vd_ff[STEPS];

   always_comb begin
      rsp_data.red_out   = ov_ff[STEPS][0] ? 8'hFF : q_ff[STEPS][0];
      rsp_data.green_out = ov_ff[STEPS][1] ? 8'hFF : q_ff[STEPS][1];
      rsp_data.blue_out  = ov_ff[STEPS][2] ? 8'hFF : q_ff[STEPS][2];
      rsp_data.clipped   = ov_ff[STEPS][0] | ov_ff[STEPS][1] | ov_ff[STEPS][2];
   end

endmodule
`default_nettype wire

// ===== design/rtm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtm_checker
// Port-level checks for reinhard_tone_map_pixel, bound to the top level.
// ----------------------------------------------------------------------------
module rtm_checker
   import rtm_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire pix_in_type  req_data,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire pix_out_type rsp_data
);

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // backpressure only when a result is held
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without output backpressure");

   // clipped pixel has a saturated channel
   a_clip_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.clipped) |->
         (rsp_data.red_out == 8'hFF || rsp_data.green_out == 8'hFF ||
          rsp_data.blue_out == 8'hFF))
      else $error("clipped set with no saturated channel");

   // held result stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind reinhard_tone_map_pixel rtm_checker u_rtm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for reinhard_tone_map_pixel.
// Drives HDR pixels with random gaps, stalls the result side at random and
// once for a long hold-off, and compares each tone-mapped pixel in order
// against a fixed-point luminance/division model of the operator.
// ----------------------------------------------------------------------------
module tb;
   import rtm_pkg::*;

   class pixel_scoreboard;
      pix_out_type pending[$];
      int errors;
      int checked;
      int clip_count;

      function pix_out_type tone_map(pix_in_type p);
         logic [63:0] wsum, lum, div, q;
         logic [63:0] chan[3];
         pix_out_type o;
         logic [7:0] v[3];
         o = '0;
         chan[0] = {32'd0, p.red_in};
         chan[1] = {32'd0, p.green_in};
         chan[2] = {32'd0, p.blue_in};
         wsum = 64'(W_RED) * chan[0] + 64'(W_GREEN) * chan[1] + 64'(W_BLUE) * chan[2];
         lum = wsum >> WEIGHT_SHIFT;
         div = (64'd1 << 16) + lum;
         for (int i = 0; i < 3; i++) begin
            q = (64'd255 * chan[i]) / div;
            if (q > 64'd255) begin
               q = 64'd255;
               o.clipped = 1'b1;
            end
            v[i] = q[7:0];
         end
         o.red_out = v[0];
         o.green_out = v[1];
         o.blue_out = v[2];
         return o;
      endfunction

      function void note_pixel(pix_in_type p);
         pending.push_back(tone_map(p));
      endfunction

      function void check_pixel(pix_out_type got);
         pix_out_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (want.clipped) clip_count++;
         if (got.red_out !== want.red_out)
            $display("%0t: red expected %0d actual %0d", $time, want.red_out, got.red_out);
         if (got.green_out !== want.green_out)
            $display("%0t: green expected %0d actual %0d", $time, want.green_out,
               got.green_out);
         if (got.blue_out !== want.blue_out)
            $display("%0t: blue expected %0d actual %0d", $time, want.blue_out,
               got.blue_out);
         if (got.clipped !== want.clipped)
            $display("%0t: clipped expected %0b actual %0b", $time, want.clipped,
               got.clipped);
         if (got !== want) errors++;
      endfunction
   endclass

   localparam int NUM_RANDOM = 1930;
   localparam int CYCLE_LIMIT = 200000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   pix_in_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   pix_out_type rsp_data;

   pixel_scoreboard board = new();
   bit quiet = 0;
   bit hold_off = 0;
   bit stim_done = 0;
   int cycles = 0;

   reinhard_tone_map_pixel uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) board.check_pixel(rsp_data);
   end

   always @(negedge clock) begin
      if (hold_off) rsp_stall <= 1'b1;
      else if (quiet) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < 33);
   end

   function automatic logic [31:0] rand_chan();
      case ($urandom_range(5))
         0: return $urandom;
         1: return $urandom_range(32'h0003_ffff);
         2: return $urandom_range(32'h0000_00ff);
         3: return 32'hffff_ffff - $urandom_range(255);
         default: return $urandom_range(32'h0010_0000);
      endcase
   endfunction

   task automatic send_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b);
      while (!quiet && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{red_in: r, green_in: g, blue_in: b};
      do @(posedge clock); while (req_stall);
      board.note_pixel('{red_in: r, green_in: g, blue_in: b});
      @(negedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_pixel(0, 0, 0);
      send_pixel(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      send_pixel(32'hffff_ffff, 0, 0);
      send_pixel(0, 32'hffff_ffff, 0);
      send_pixel(0, 0, 32'hffff_ffff);
      send_pixel(1, 0, 0);
      send_pixel(0, 0, 1);
      send_pixel(4, 1, 13);
      send_pixel(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_pixel(32'h0001_0000, 0, 0);
      send_pixel(32'h0000_0100, 0, 0);
      send_pixel(0, 32'h0000_8000, 0);
      send_pixel(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
      send_pixel(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
      send_pixel(32'h0010_0000, 32'h0000_0001, 32'h0100_0000);
      hold_off = 1;
      fork
         begin
            repeat (60) @(posedge clock);
            hold_off = 0;
         end
         for (int i = 0; i < 40; i++) send_pixel(rand_chan(), rand_chan(), rand_chan());
      join
      for (int i = 0; i < NUM_RANDOM; i++) begin
         quiet = (i >= 600 && i < 900);
         send_pixel(rand_chan(), rand_chan(), rand_chan());
      end
      quiet = 0;
      req_valid <= 1'b0;
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      $display("checked %0d pixels, %0d with a clipped channel", board.checked,
         board.clip_count);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
